// ===== design/smeu_pkg.sv =====
// Package for the stack machine execute unit: opcodes, error codes, types.
// No dependencies.
package smeu_pkg;
    localparam logic [4:0] OP_PUSH_IMM = 5'd0;
    localparam logic [4:0] OP_LOAD     = 5'd1;
    localparam logic [4:0] OP_SAVE     = 5'd2;
    localparam logic [4:0] OP_POP      = 5'd3;
    localparam logic [4:0] OP_ADD      = 5'd4;
    localparam logic [4:0] OP_SUB      = 5'd5;
    localparam logic [4:0] OP_MUL      = 5'd6;
    localparam logic [4:0] OP_DIV      = 5'd7;
    localparam logic [4:0] OP_EQ       = 5'd8;
    localparam logic [4:0] OP_LT       = 5'd9;
    localparam logic [4:0] OP_GT       = 5'd10;
    localparam logic [4:0] OP_NOT      = 5'd11;
    localparam logic [4:0] OP_JMP      = 5'd12;
    localparam logic [4:0] OP_JZ       = 5'd13;
    localparam logic [4:0] OP_EMIT     = 5'd14;
    localparam logic [4:0] OP_PUSH_IN  = 5'd15;
    localparam logic [4:0] OP_HALT     = 5'd16;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_UNDER = 2'd1;
    localparam logic [1:0] ERR_OVER  = 2'd2;
    localparam logic [1:0] ERR_DIV0  = 2'd3;

    typedef struct packed {
        logic [4:0]  op;
        logic        start;
        logic [31:0] imm;
        logic [7:0]  vidx;
        logic [15:0] target;
        logic [31:0] inval;
        logic [2:0]  len;
        logic [1:0]  pops;
        logic        push;
    } t_instr;

    typedef struct packed {
        logic [15:0] next_ip;
        logic        pvalid;
        logic [31:0] pval;
        logic        halt;
        logic        done;
        logic [1:0]  err;
    } t_result;
endpackage

// ===== design/stack_machine_execute_unit.sv =====
// Stack machine execute unit top: front queue, back executor, config register.
// Depends on smeu_pkg, smeu_front, smeu_back, smeu_ram.
// The back end works on one item at a time and holds each result until it is accepted,
// then takes the next item from the front queue.
// Reset and start_run: a variable-store clearing pass over all VAR_COUNT entries; the back end takes no items.
module stack_machine_execute_unit #(
    parameter int STACK_DEPTH = 256,
    parameter int VAR_COUNT = 256
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [15:0]  i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,  // req_type, imm_value, var_index, jump_target, input_value
    input  logic         s_axis_tuser,  // start_run
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [55:0]  m_axis_tdata   // next_ip, print_valid, print_value, halted, run_done, error_code
);
    logic [15:0] r_plen;
    smeu_pkg::t_instr in_i, q_i;
    smeu_pkg::t_result res;
    logic q_v, q_r;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_plen <= '0;
        else if (i_cfg_we) r_plen <= i_cfg_wdata;
    end

    always_comb begin
        in_i = '0;
        in_i.op = s_axis_tdata[4:0];
        in_i.imm = s_axis_tdata[36:5];
        in_i.vidx = s_axis_tdata[44:37];
        in_i.target = s_axis_tdata[60:45];
        in_i.inval = s_axis_tdata[92:61];
        in_i.start = s_axis_tuser;
    end

    smeu_front u_front (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(s_axis_tvalid),
        .o_ready(s_axis_tready), .i_instr(in_i), .o_valid(q_v), .i_ready(q_r),
        .o_instr(q_i));
    smeu_back #(.STACK_DEPTH(STACK_DEPTH), .VAR_COUNT(VAR_COUNT)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(q_v), .o_ready(q_r), .i_instr(q_i),
        .i_prog_len(r_plen), .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_result(res));

    assign m_axis_tdata = {3'd0, res.err, res.done, res.halt, res.pval, res.pvalid,
                           res.next_ip};

    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[49] |-> m_axis_tdata[52:51] == smeu_pkg::ERR_NONE)
        else $error("halt with error");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped");
endmodule

// ===== design/smeu_ram.sv =====
// Generic single-write, single-read RAM with registered read.
// No dependencies.
module smeu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== design/smeu_front.sv =====
// Front end: accepts items, classifies length and stack use, feeds a 2-entry queue.
// Depends on smeu_pkg.
module smeu_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  smeu_pkg::t_instr  i_instr,
    output logic              o_valid,
    input  logic              i_ready,
    output smeu_pkg::t_instr  o_instr
);
    smeu_pkg::t_instr r_q [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    smeu_pkg::t_instr c;

    always_comb begin
        c = i_instr;
        c.len = 3'd1;
        c.pops = 2'd0;
        c.push = 1'b0;
        case (i_instr.op)
            smeu_pkg::OP_PUSH_IMM: begin c.len = 3'd5; c.push = 1'b1; end
            smeu_pkg::OP_LOAD: begin c.len = 3'd2; c.push = 1'b1; end
            smeu_pkg::OP_PUSH_IN: c.push = 1'b1;
            smeu_pkg::OP_SAVE: begin c.len = 3'd2; c.pops = 2'd1; end
            smeu_pkg::OP_JMP: c.len = 3'd3;
            smeu_pkg::OP_JZ: begin c.len = 3'd3; c.pops = 2'd1; end
            smeu_pkg::OP_POP, smeu_pkg::OP_NOT, smeu_pkg::OP_EMIT: c.pops = 2'd1;
            default: begin
                if (i_instr.op inside {[smeu_pkg::OP_ADD:smeu_pkg::OP_GT]}) c.pops = 2'd2;
            end
        endcase
    end

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_instr = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (i_valid && o_ready) begin
                r_q[r_wp] <= c;
                r_wp <= ~r_wp;
            end
            if (o_valid && i_ready) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'((i_valid && o_ready) ? 1 : 0) - 2'((o_valid && i_ready) ? 1 : 0);
        end
    end
endmodule

// ===== design/smeu_back.sv =====
// Back end: executes one instruction against stack and variable RAMs.
// Depends on smeu_pkg, smeu_ram. Variables cleared by sweep after reset/start_run.
module smeu_back #(
    parameter int STACK_DEPTH = 256,
    parameter int VAR_COUNT = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  smeu_pkg::t_instr  i_instr,
    input  logic [15:0]       i_prog_len,
    output logic              o_valid,
    input  logic              i_ready,
    output smeu_pkg::t_result o_result
);
    localparam int SW = $clog2(STACK_DEPTH);
    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int VW = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1;
    localparam logic [3:0] S_IDLE = 4'd0, S_RD1 = 4'd1, S_RD2 = 4'd2, S_EXE = 4'd3,
        S_DIV = 4'd4, S_MUL = 4'd5, S_CLR = 4'd6, S_OUT = 4'd7;

    logic [3:0] r_st;
    smeu_pkg::t_instr r_in;
    logic [DW-1:0] r_dep;
    logic [15:0] r_ip;
    logic [31:0] r_a;
    logic [31:0] alu_res;
    logic [VW:0] r_clr;
    logic r_vclr;
    logic [5:0] r_dcnt;
    logic [31:0] r_quo, r_rem, r_ua, r_ub;
    logic r_neg;
    logic [31:0] r_prod;
    smeu_pkg::t_result r_res;

    logic s_we; logic [SW-1:0] s_wa, s_ra; logic [31:0] s_wd, s_rd;
    logic v_we; logic [VW-1:0] v_wa, v_ra; logic [31:0] v_wd, v_rd;

    smeu_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stk (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_wa), .i_wdata(s_wd),
        .i_raddr(s_ra), .o_rdata(s_rd));
    smeu_ram #(.WIDTH(32), .DEPTH(VAR_COUNT)) u_var (
        .i_clk(i_clk), .i_we(v_we), .i_waddr(v_wa), .i_wdata(v_wd),
        .i_raddr(v_ra), .o_rdata(v_rd));

    logic [DW-1:0] dep_eff;
    logic vok;
    logic [32:0] dsub;
    assign dep_eff = r_in.start ? '0 : r_dep;
    assign vok = ({24'd0, r_in.vidx} < 32'(VAR_COUNT));
    assign dsub = {r_rem[31:0], r_ua[31]} - {1'b0, r_ub};
    assign o_ready = (r_st == S_IDLE) && !r_vclr;
    assign o_valid = (r_st == S_OUT);
    assign o_result = r_res;

    // read addresses: top in RD1, second in RD2
    always_comb begin
        s_ra = SW'(dep_eff - DW'(2));
        if (r_st == S_RD1) s_ra = SW'(dep_eff - DW'(1));
        v_ra = VW'(r_in.vidx);
        v_we = r_vclr;
        v_wa = VW'(r_clr);
        v_wd = '0;
        s_we = 1'b0; s_wa = '0; s_wd = '0;
        if (r_st == S_EXE && !r_vclr) begin
            if (r_in.push && dep_eff < DW'(STACK_DEPTH)) begin
                s_we = 1'b1; s_wa = SW'(dep_eff);
                case (r_in.op)
                    smeu_pkg::OP_PUSH_IMM: s_wd = r_in.imm;
                    smeu_pkg::OP_LOAD: s_wd = vok ? (r_in.start ? 32'd0 : v_rd) : 32'd0;
                    default: s_wd = r_in.inval;
                endcase
            end else if (r_in.op == smeu_pkg::OP_SAVE && dep_eff != '0 && vok) begin
                v_we = 1'b1; v_wa = VW'(r_in.vidx); v_wd = r_a;
            end else if (r_in.op == smeu_pkg::OP_NOT && dep_eff != '0) begin
                s_we = 1'b1; s_wa = SW'(dep_eff - DW'(1)); s_wd = {31'd0, r_a == 32'd0};
            end else if (r_in.pops == 2'd2 && dep_eff >= DW'(2)
                         && !(r_in.op == smeu_pkg::OP_DIV && r_a == 32'd0)
                         && r_in.op != smeu_pkg::OP_MUL) begin
                s_we = 1'b1; s_wa = SW'(dep_eff - DW'(2)); s_wd = alu_res;
            end
        end else if (r_st == S_DIV && r_dcnt == 6'd32) begin
            // depth already holds the popped value here
            s_we = 1'b1; s_wa = SW'(dep_eff - DW'(1));
            s_wd = r_neg ? (32'd0 - r_quo) : r_quo;
        end else if (r_st == S_MUL) begin
            s_we = 1'b1; s_wa = SW'(dep_eff - DW'(1)); s_wd = r_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_dep <= '0; r_ip <= '0; r_vclr <= 1'b1; r_clr <= '0;
        end else begin
            if (r_vclr) begin
                r_clr <= r_clr + 1'b1;
                if (r_clr == (VW+1)'(VAR_COUNT - 1)) r_vclr <= 1'b0;
            end
            case (r_st)
                S_IDLE: if (i_valid && !r_vclr) begin
                    r_in <= i_instr;
                    r_st <= S_RD1;
                end
                S_RD1: r_st <= S_RD2;
                S_RD2: begin r_a <= s_rd; r_st <= S_EXE; end
                S_EXE: begin
                    logic [31:0] b, a;
                    logic [1:0] e;
                    logic [15:0] nip;
                    logic pv, jmp;
                    logic [DW-1:0] nd;
                    b = r_a; a = s_rd; e = smeu_pkg::ERR_NONE; pv = 1'b0; jmp = 1'b0;
                    nd = dep_eff;
                    if (r_in.push) begin
                        if (dep_eff >= DW'(STACK_DEPTH)) e = smeu_pkg::ERR_OVER;
                        else nd = dep_eff + DW'(1);
                    end else if (r_in.pops != 2'd0 && dep_eff < DW'(r_in.pops))
                        e = smeu_pkg::ERR_UNDER;
                    else if (r_in.op == smeu_pkg::OP_DIV && b == 32'd0)
                        e = smeu_pkg::ERR_DIV0;
                    else if (r_in.pops == 2'd2 || r_in.op == smeu_pkg::OP_POP
                             || r_in.op == smeu_pkg::OP_EMIT) begin
                        nd = dep_eff - DW'(1);
                        pv = (r_in.op == smeu_pkg::OP_EMIT);
                    end
                    if (r_in.op == smeu_pkg::OP_JMP) jmp = 1'b1;
                    if (r_in.op == smeu_pkg::OP_JZ && dep_eff != '0 && b == 32'd0) jmp = 1'b1;
                    nip = jmp ? r_in.target : ((r_in.start ? 16'd0 : r_ip) + 16'(r_in.len));
                    r_ip <= nip;
                    r_dep <= nd;
                    r_res.next_ip <= nip;
                    r_res.pvalid <= pv;
                    r_res.pval <= pv ? b : 32'd0;
                    r_res.halt <= (r_in.op == smeu_pkg::OP_HALT);
                    r_res.done <= (nip >= i_prog_len);
                    r_res.err <= e;
                    if (r_in.start && !r_vclr) begin r_vclr <= 1'b1; r_clr <= '0; end
                    if (e == smeu_pkg::ERR_NONE && r_in.op == smeu_pkg::OP_DIV) begin
                        r_neg <= a[31] ^ b[31];
                        r_ua <= a[31] ? (32'd0 - a) : a;
                        r_ub <= b[31] ? (32'd0 - b) : b;
                        r_rem <= '0; r_dcnt <= '0; r_st <= S_DIV;
                    end else if (e == smeu_pkg::ERR_NONE && r_in.op == smeu_pkg::OP_MUL) begin
                        r_prod <= a * b; r_st <= S_MUL;
                    end else begin
                        r_st <= S_OUT;
                    end
                end
                S_DIV: begin
                    if (r_dcnt == 6'd32) r_st <= S_OUT;
                    else begin
                        if (!dsub[32]) begin
                            r_rem <= dsub[31:0]; r_quo <= {r_quo[30:0], 1'b1};
                        end else begin
                            r_rem <= {r_rem[30:0], r_ua[31]}; r_quo <= {r_quo[30:0], 1'b0};
                        end
                        r_ua <= {r_ua[30:0], 1'b0};
                        r_dcnt <= r_dcnt + 6'd1;
                    end
                end
                S_MUL: r_st <= S_OUT;
                S_OUT: if (i_ready) r_st <= S_IDLE;
                default: r_st <= S_IDLE;
            endcase
        end
    end

    // add/sub/eq/lt/gt result (else 0) from RAM second (a) and registered top (b)
    always_comb begin
        logic [31:0] a, b;
        a = s_rd; b = r_a;
        case (r_in.op)
            smeu_pkg::OP_ADD: alu_res = a + b;
            smeu_pkg::OP_SUB: alu_res = a - b;
            smeu_pkg::OP_EQ: alu_res = {31'd0, a == b};
            smeu_pkg::OP_LT: alu_res = {31'd0, $signed(a) < $signed(b)};
            smeu_pkg::OP_GT: alu_res = {31'd0, $signed(b) < $signed(a)};
            default: alu_res = '0;
        endcase
    end
endmodule
